// ===== design/assert_macros.svh =====
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define BCM_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bcm assertion failed");

// next-cycle implication, disabled while reset is asserted
`define BCM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bcm assertion failed");

`endif

// ===== design/bcm_pkg.sv =====
// shared types and constants of the battery charge monitor
// no dependencies
`timescale 1ns / 1ps

package bcm_pkg;

    localparam int ADC_BITS          = 12;
    localparam int BOOT_SYNC_SAMPLES = 10;
    localparam int BOOT_W            = 16;

    // adc scaling to 10 mV units: raw * SCALE_NUM / SCALE_DEN, done as a multiply by a
    // rounded-up reciprocal; 2^SCALE_SHIFT exceeds full scale times the reduced
    // denominator 8463, so the truncated quotient is exact for every code
    localparam int SCALE_NUM   = 205260;
    localparam int SCALE_DEN   = 253890;
    localparam int SCALE_SHIFT = ADC_BITS + 14;
    localparam int MUL_W       = SCALE_SHIFT;
    localparam logic [MUL_W-1:0] SCALE_MUL =
        MUL_W'(((64'(SCALE_NUM) << SCALE_SHIFT) + 64'(SCALE_DEN) - 64'd1) / 64'(SCALE_DEN));
    localparam int PROD_W      = ADC_BITS + MUL_W;

    localparam int THR_W   = 16;
    localparam int LEVEL_W = 3;
    localparam int TIME_W  = 32;
    localparam int HP_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LEVEL5_THR  = 3'd0,
        REG_LEVEL4_THR  = 3'd1,
        REG_LEVEL3_THR  = 3'd2,
        REG_LEVEL2_THR  = 3'd3,
        REG_LEVEL1_THR  = 3'd4,
        REG_CHARGER_THR = 3'd5,
        REG_LOW_LEVEL   = 3'd6,
        REG_BLINK_HALF  = 3'd7
    } reg_index_t;

    typedef enum logic [1:0] {
        CHG_IDLE     = 2'd0,
        CHG_CHARGING = 2'd1,
        CHG_FULL     = 2'd2
    } charge_state_t;

    typedef struct packed {
        logic [THR_W-1:0]   level5_threshold;
        logic [THR_W-1:0]   level4_threshold;
        logic [THR_W-1:0]   level3_threshold;
        logic [THR_W-1:0]   level2_threshold;
        logic [THR_W-1:0]   level1_threshold;
        logic [THR_W-1:0]   charger_threshold;
        logic [LEVEL_W-1:0] low_level_max;
        logic [HP_W-1:0]    blink_half_period;
    } cfg_t;

    // classified sample handed from the front to the back
    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic               has_dc;
        charge_state_t      state;
        logic [TIME_W-1:0]  time_ms;
        logic               startup;
    } item_t;

endpackage

// ===== design/bcm_fifo.sv =====
// short queue between the front and back parts
// depends on bcm_pkg
`timescale 1ns / 1ps

module bcm_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  bcm_pkg::item_t push_item,
    output logic           full,
    input  logic           pop,
    output bcm_pkg::item_t pop_item,
    output logic           empty
);

    localparam int PTR_W = $clog2(bcm_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(bcm_pkg::QUEUE_DEPTH + 1);

    bcm_pkg::item_t   mem_reg [bcm_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == CNT_W'(bcm_pkg::QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_item = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(bcm_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                            : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(bcm_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                            : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== design/bcm_front.sv =====
// front part: takes samples, scales both adc codes, quantizes and classifies
// depends on bcm_pkg
`timescale 1ns / 1ps

module bcm_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [bcm_pkg::ADC_BITS-1:0]      battery_raw,
    input  logic [bcm_pkg::ADC_BITS-1:0]      charger_raw,
    input  logic                              charging_pin_active,
    input  logic                              done_pin_active,
    input  logic [bcm_pkg::TIME_W-1:0]        time_ms,
    input  logic                              startup_mode,
    input  bcm_pkg::cfg_t                     cfg,
    output logic                              push,
    output bcm_pkg::item_t                    push_item,
    input  logic                              full
);

    localparam int QUO_W  = bcm_pkg::ADC_BITS;
    localparam int PROD_W = bcm_pkg::PROD_W;
    localparam int SHIFT  = bcm_pkg::SCALE_SHIFT;

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_MUL  = 3'b010,
        F_PUSH = 3'b100
    } front_state_t;

    front_state_t                state_reg, state_next;

    logic [QUO_W-1:0]            bat_raw_reg, bat_raw_next;
    logic [QUO_W-1:0]            dc_raw_reg, dc_raw_next;
    logic [QUO_W-1:0]            bat_q_reg, bat_q_next;
    logic [QUO_W-1:0]            dc_q_reg, dc_q_next;
    logic                        chg_pin_reg, chg_pin_next;
    logic                        done_pin_reg, done_pin_next;
    logic [bcm_pkg::TIME_W-1:0]  time_reg, time_next;
    logic                        startup_reg, startup_next;

    logic [PROD_W-1:0]           bat_prod, dc_prod;
    logic [bcm_pkg::THR_W-1:0]   bat_ext, dc_ext;
    logic [bcm_pkg::LEVEL_W-1:0] level;
    logic                        has_dc;
    bcm_pkg::charge_state_t      chg_state;

    assign in_ready = (state_reg == F_IDLE);

    // scaled value is the top bits of raw times the reciprocal
    assign bat_prod = PROD_W'(bat_raw_reg) * PROD_W'(bcm_pkg::SCALE_MUL);
    assign dc_prod  = PROD_W'(dc_raw_reg) * PROD_W'(bcm_pkg::SCALE_MUL);

    // quantize and classify from the registered quotients
    assign bat_ext = bcm_pkg::THR_W'(bat_q_reg);
    assign dc_ext  = bcm_pkg::THR_W'(dc_q_reg);
    assign has_dc  = (dc_ext > cfg.charger_threshold);

    always_comb
    begin
        if (bat_ext >= cfg.level5_threshold)
        begin
            level = 3'd5;
        end
        else if (bat_ext >= cfg.level4_threshold)
        begin
            level = 3'd4;
        end
        else if (bat_ext >= cfg.level3_threshold)
        begin
            level = 3'd3;
        end
        else if (bat_ext >= cfg.level2_threshold)
        begin
            level = 3'd2;
        end
        else if (bat_ext >= cfg.level1_threshold)
        begin
            level = 3'd1;
        end
        else
        begin
            level = 3'd0;
        end
    end

    always_comb
    begin
        if (has_dc && chg_pin_reg)
        begin
            chg_state = done_pin_reg ? bcm_pkg::CHG_FULL : bcm_pkg::CHG_CHARGING;
        end
        else
        begin
            chg_state = bcm_pkg::CHG_IDLE;
        end
    end

    assign push              = (state_reg == F_PUSH);
    assign push_item.level   = level;
    assign push_item.has_dc  = has_dc;
    assign push_item.state   = chg_state;
    assign push_item.time_ms = time_reg;
    assign push_item.startup = startup_reg;

    always_comb
    begin
        state_next    = state_reg;
        bat_raw_next  = bat_raw_reg;
        dc_raw_next   = dc_raw_reg;
        bat_q_next    = bat_q_reg;
        dc_q_next     = dc_q_reg;
        chg_pin_next  = chg_pin_reg;
        done_pin_next = done_pin_reg;
        time_next     = time_reg;
        startup_next  = startup_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (in_valid)
                begin
                    bat_raw_next  = battery_raw;
                    dc_raw_next   = charger_raw;
                    chg_pin_next  = charging_pin_active;
                    done_pin_next = done_pin_active;
                    time_next     = time_ms;
                    startup_next  = startup_mode;
                    state_next    = F_MUL;
                end
            end
            F_MUL:
            begin
                bat_q_next = bat_prod[PROD_W-1:SHIFT];
                dc_q_next  = dc_prod[PROD_W-1:SHIFT];
                state_next = F_PUSH;
            end
            F_PUSH:
            begin
                if (!full)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bat_raw_reg  <= bat_raw_next;
        dc_raw_reg   <= dc_raw_next;
        bat_q_reg    <= bat_q_next;
        dc_q_reg     <= dc_q_next;
        chg_pin_reg  <= chg_pin_next;
        done_pin_reg <= done_pin_next;
        time_reg     <= time_next;
        startup_reg  <= startup_next;
    end

endmodule

// ===== design/bcm_back.sv =====
// back part: level tracking, blink phase divider, led drive and output register
// depends on bcm_pkg
`timescale 1ns / 1ps

module bcm_back #(
    parameter int BOOT_SYNC_SAMPLES = bcm_pkg::BOOT_SYNC_SAMPLES
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bcm_pkg::cfg_t                 cfg,
    input  logic                          empty,
    input  bcm_pkg::item_t                pop_item,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [bcm_pkg::LEVEL_W-1:0]   battery_level,
    output logic [1:0]                    charge_state,
    output logic                          red_led,
    output logic                          green_led
);

    localparam int TIME_W = bcm_pkg::TIME_W;
    localparam int HP_W   = bcm_pkg::HP_W;
    localparam int BIT_W  = $clog2(TIME_W);
    localparam int BOOT_W = bcm_pkg::BOOT_W;
    localparam int LVL_W  = bcm_pkg::LEVEL_W;

    typedef enum logic [2:0] {
        B_IDLE = 3'b001,
        B_DIV  = 3'b010,
        B_DONE = 3'b100
    } back_state_t;

    back_state_t             state_reg, state_next;

    // tracking state
    logic [LVL_W-1:0]        level_now_reg, level_now_next;
    logic [LVL_W-1:0]        boot_peak_reg, boot_peak_next;
    logic [BOOT_W-1:0]       boot_rem_reg, boot_rem_next;
    logic                    boot_active_reg, boot_active_next;

    // current item
    bcm_pkg::charge_state_t  chg_reg, chg_next;
    logic                    has_dc_reg, has_dc_next;
    logic                    startup_reg, startup_next;

    // blink phase divider
    logic [TIME_W-1:0]       t_reg, t_next;
    logic [HP_W-1:0]         hp_reg, hp_next;
    logic [HP_W-1:0]         rem_reg, rem_next;
    logic [BIT_W-1:0]        bit_reg, bit_next;
    logic                    q_lsb_reg, q_lsb_next;
    logic [HP_W:0]           rem_sh;

    // output register
    logic                    out_valid_reg, out_valid_next;
    logic [LVL_W-1:0]        level_out_reg, level_out_next;
    logic [1:0]              chg_out_reg, chg_out_next;
    logic                    red_reg, red_next;
    logic                    green_reg, green_next;

    logic                    out_free;
    logic                    led_red, led_green;
    logic [LVL_W-1:0]        peak_cand;

    assign out_free      = !out_valid_reg || out_ready;
    assign pop           = (state_reg == B_IDLE) && !empty;
    assign rem_sh        = {rem_reg, t_reg[TIME_W-1]};
    assign peak_cand     = (pop_item.level > boot_peak_reg) ? pop_item.level : boot_peak_reg;

    assign out_valid     = out_valid_reg;
    assign battery_level = level_out_reg;
    assign charge_state  = chg_out_reg;
    assign red_led       = red_reg;
    assign green_led     = green_reg;

    // led drive from the updated level
    always_comb
    begin
        led_red   = 1'b0;
        led_green = 1'b0;
        if (!(startup_reg && chg_reg != bcm_pkg::CHG_CHARGING))
        begin
            if (chg_reg == bcm_pkg::CHG_CHARGING)
            begin
                led_green = !q_lsb_reg;
            end
            else if (has_dc_reg && chg_reg == bcm_pkg::CHG_FULL)
            begin
                led_green = 1'b1;
            end
            else if (level_now_reg <= cfg.low_level_max)
            begin
                led_red = 1'b1;
            end
            else
            begin
                led_green = 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        level_now_next   = level_now_reg;
        boot_peak_next   = boot_peak_reg;
        boot_rem_next    = boot_rem_reg;
        boot_active_next = boot_active_reg;
        chg_next         = chg_reg;
        has_dc_next      = has_dc_reg;
        startup_next     = startup_reg;
        t_next           = t_reg;
        hp_next          = hp_reg;
        rem_next         = rem_reg;
        bit_next         = bit_reg;
        q_lsb_next       = q_lsb_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        level_out_next   = level_out_reg;
        chg_out_next     = chg_out_reg;
        red_next         = red_reg;
        green_next       = green_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (!empty)
                begin
                    chg_next     = pop_item.state;
                    has_dc_next  = pop_item.has_dc;
                    startup_next = pop_item.startup;
                    t_next       = pop_item.time_ms;
                    hp_next      = (cfg.blink_half_period == '0) ? HP_W'(1)
                                                                 : cfg.blink_half_period;
                    rem_next     = '0;
                    bit_next     = BIT_W'(TIME_W - 1);
                    if (boot_active_reg && !pop_item.has_dc)
                    begin
                        boot_peak_next = peak_cand;
                        if (peak_cand > level_now_reg)
                        begin
                            level_now_next = peak_cand;
                        end
                        if (boot_rem_reg <= BOOT_W'(1))
                        begin
                            boot_rem_next    = '0;
                            boot_active_next = 1'b0;
                        end
                        else
                        begin
                            boot_rem_next = boot_rem_reg - 1'b1;
                        end
                    end
                    else
                    begin
                        boot_active_next = 1'b0;
                        if (pop_item.level < level_now_reg)
                        begin
                            level_now_next = pop_item.level;
                        end
                        else if (pop_item.level > level_now_reg && pop_item.has_dc)
                        begin
                            level_now_next = pop_item.level;
                        end
                    end
                    state_next = (pop_item.state == bcm_pkg::CHG_CHARGING) ? B_DIV : B_DONE;
                end
            end
            B_DIV:
            begin
                // one quotient bit of time / half period per cycle, only the last is kept
                if (rem_sh >= {1'b0, hp_reg})
                begin
                    rem_next   = HP_W'(rem_sh - {1'b0, hp_reg});
                    q_lsb_next = 1'b1;
                end
                else
                begin
                    rem_next   = HP_W'(rem_sh);
                    q_lsb_next = 1'b0;
                end
                t_next = {t_reg[TIME_W-2:0], 1'b0};
                if (bit_reg == '0)
                begin
                    state_next = B_DONE;
                end
                else
                begin
                    bit_next = bit_reg - 1'b1;
                end
            end
            B_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    level_out_next = level_now_reg;
                    chg_out_next   = chg_reg;
                    red_next       = led_red;
                    green_next     = led_green;
                    state_next     = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= B_IDLE;
            level_now_reg   <= '0;
            boot_peak_reg   <= '0;
            boot_rem_reg    <= BOOT_W'(BOOT_SYNC_SAMPLES);
            boot_active_reg <= 1'b1;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            level_now_reg   <= level_now_next;
            boot_peak_reg   <= boot_peak_next;
            boot_rem_reg    <= boot_rem_next;
            boot_active_reg <= boot_active_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chg_reg       <= chg_next;
        has_dc_reg    <= has_dc_next;
        startup_reg   <= startup_next;
        t_reg         <= t_next;
        hp_reg        <= hp_next;
        rem_reg       <= rem_next;
        bit_reg       <= bit_next;
        q_lsb_reg     <= q_lsb_next;
        level_out_reg <= level_out_next;
        chg_out_reg   <= chg_out_next;
        red_reg       <= red_next;
        green_reg     <= green_next;
    end

endmodule

// ===== design/battery_charge_monitor.sv =====
// top level of the battery charge monitor: register file, front, queue and back
// depends on bcm_pkg, bcm_fifo, bcm_front and bcm_back
`timescale 1ns / 1ps

//  channel   handshake              payload
//  in        in_valid / in_ready    battery_raw, charger_raw, charging_pin_active,
//                                   done_pin_active, time_ms, startup_mode
//  out       out_valid / out_ready  battery_level, charge_state, red_led, green_led
//  cfg       cfg_valid / cfg_ready  cfg_index, cfg_data
//
//  the front captures a sample, multiplies both adc codes by a fixed reciprocal of the
//  scale and hands it to the queue, taking no new sample until the queue accepts it
//  the back works through one sample at a time; while charging, a bit-serial divider
//  works out the blink phase from time_ms, one bit a cycle over 32 bits
//  reset is asynchronous and active low, loads the register defaults and opens the
//  boot window; a two-entry queue and the output register absorb back-end stalls

module battery_charge_monitor #(
    parameter int BOOT_SYNC_SAMPLES = bcm_pkg::BOOT_SYNC_SAMPLES
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // sample transaction
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [bcm_pkg::ADC_BITS-1:0]      battery_raw,
    input  logic [bcm_pkg::ADC_BITS-1:0]      charger_raw,
    input  logic                              charging_pin_active,
    input  logic                              done_pin_active,
    input  logic [bcm_pkg::TIME_W-1:0]        time_ms,
    input  logic                              startup_mode,
    // result transaction
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [bcm_pkg::LEVEL_W-1:0]       battery_level,
    output logic [1:0]                        charge_state,
    output logic                              red_led,
    output logic                              green_led,
    // register write transaction
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bcm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bcm_pkg::CFG_DATA_W-1:0]    cfg_data
);

    bcm_pkg::cfg_t  cfg_reg, cfg_next;
    bcm_pkg::item_t push_item, pop_item;
    logic           push, pop, full, empty;

    // register writes are always taken; they must arrive only while the block is idle, which the block does not enforce
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (bcm_pkg::reg_index_t'(cfg_index))
                bcm_pkg::REG_LEVEL5_THR:  cfg_next.level5_threshold  = cfg_data;
                bcm_pkg::REG_LEVEL4_THR:  cfg_next.level4_threshold  = cfg_data;
                bcm_pkg::REG_LEVEL3_THR:  cfg_next.level3_threshold  = cfg_data;
                bcm_pkg::REG_LEVEL2_THR:  cfg_next.level2_threshold  = cfg_data;
                bcm_pkg::REG_LEVEL1_THR:  cfg_next.level1_threshold  = cfg_data;
                bcm_pkg::REG_CHARGER_THR: cfg_next.charger_threshold = cfg_data;
                bcm_pkg::REG_LOW_LEVEL:
                    cfg_next.low_level_max = cfg_data[bcm_pkg::LEVEL_W-1:0];
                bcm_pkg::REG_BLINK_HALF:  cfg_next.blink_half_period = cfg_data;
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    // defaults: 4.10, 3.95, 3.82, 3.70 and 3.55 v thresholds, 4.50 v charger detect
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.level5_threshold  <= 16'd410;
            cfg_reg.level4_threshold  <= 16'd395;
            cfg_reg.level3_threshold  <= 16'd382;
            cfg_reg.level2_threshold  <= 16'd370;
            cfg_reg.level1_threshold  <= 16'd355;
            cfg_reg.charger_threshold <= 16'd450;
            cfg_reg.low_level_max     <= 3'd1;
            cfg_reg.blink_half_period <= 16'd500;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // scaling, quantizing and charge classification
    bcm_front u_front (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_ready            (in_ready),
        .battery_raw         (battery_raw),
        .charger_raw         (charger_raw),
        .charging_pin_active (charging_pin_active),
        .done_pin_active     (done_pin_active),
        .time_ms             (time_ms),
        .startup_mode        (startup_mode),
        .cfg                 (cfg_reg),
        .push                (push),
        .push_item           (push_item),
        .full                (full)
    );

    // decouples the two halves
    bcm_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (full),
        .pop       (pop),
        .pop_item  (pop_item),
        .empty     (empty)
    );

    // level tracking, blink phase and led drive
    bcm_back #(
        .BOOT_SYNC_SAMPLES (BOOT_SYNC_SAMPLES)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .empty         (empty),
        .pop_item      (pop_item),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .battery_level (battery_level),
        .charge_state  (charge_state),
        .red_led       (red_led),
        .green_led     (green_led)
    );

endmodule

// ===== design/bcm_checker.sv =====
// port-level checks of the battery charge monitor, bound to the top level
// depends on bcm_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bcm_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic [bcm_pkg::LEVEL_W-1:0]       battery_level,
    input logic [1:0]                        charge_state,
    input logic                              red_led,
    input logic                              green_led
);

    `BCM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(battery_level))
    `BCM_ASSERT_NOW(a_level_range, clk, rst_n, out_valid, battery_level <= 3'd5)
    `BCM_ASSERT_NOW(a_state_code, clk, rst_n, out_valid, charge_state != 2'd3)
    `BCM_ASSERT_NOW(a_led_excl, clk, rst_n, out_valid, !(red_led && green_led))
    `BCM_ASSERT_NOW(a_red_charging, clk, rst_n, out_valid && red_led, charge_state == bcm_pkg::CHG_IDLE)

endmodule

bind battery_charge_monitor bcm_checker u_bcm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .battery_level (battery_level),
    .charge_state  (charge_state),
    .red_led       (red_led),
    .green_led     (green_led)
);
